>>> rtl/core/rgbhsv_pkg.sv
// Shared types and constants for the RGB to HSV converter.
// No dependencies.
`timescale 1ns / 1ps
package rgbhsv_pkg;

  localparam int unsigned GUN_W   = 6;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned NUM_W   = 16;
  localparam int unsigned SUM_W   = 11;
  localparam int unsigned DIV_STEPS = 8;

  localparam logic [SUM_W-1:0] HUE_BASE_1 = 11'd255;
  localparam logic [SUM_W-1:0] HUE_BASE_3 = 11'd765;
  localparam logic [SUM_W-1:0] HUE_BASE_5 = 11'd1275;

  localparam logic [14:0] RECIP_63 = 15'd16645;
  localparam logic [13:0] RECIP_6  = 14'd10923;

  typedef struct packed {
    logic [NUM_W-1:0]  s_rem;
    logic [CHAN_W-1:0] s_den;
    logic [CHAN_W-1:0] s_quo;
    logic [NUM_W-1:0]  h_rem;
    logic [CHAN_W-1:0] h_den;
    logic [CHAN_W-1:0] h_quo;
    logic [SUM_W-1:0]  h_base;
    logic              h_neg;
    logic [CHAN_W-1:0] val;
  } div_word_t;

  function automatic logic [CHAN_W-1:0] scale_gun(input logic [GUN_W-1:0] g);
    logic [13:0] n;
    logic [28:0] p;
    n = 14'(16'(g) * 16'd255 + 16'd31);
    p = 29'(n) * 29'(RECIP_63);
    return p[27:20];
  endfunction

endpackage

>>> rtl/core/rgbhsv_prep.sv
// Front stages: gun scaling, value/white and hexcone sector selection.
// Depends on rgbhsv_pkg.
`timescale 1ns / 1ps
module rgbhsv_prep import rgbhsv_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [GUN_W-1:0]  red,
  input  logic [GUN_W-1:0]  green,
  input  logic [GUN_W-1:0]  blue,
  output logic              out_valid,
  output div_word_t         out_word
);

  logic              v1_r, v2_r;
  logic [CHAN_W-1:0] r_r, g_r, b_r;
  div_word_t         w_r, w_nxt;
  logic [CHAN_W-1:0] val, white, span, x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_r <= scale_gun(red);
      g_r <= scale_gun(green);
      b_r <= scale_gun(blue);
      w_r <= w_nxt;
    end
  end

  always_comb begin
    val   = (r_r > g_r) ? r_r : g_r;
    if (b_r > val) val = b_r;
    white = (r_r < g_r) ? r_r : g_r;
    if (b_r < white) white = b_r;
    span  = val - white;
    w_nxt = '0;
    if (val == r_r) begin
      if (white == g_r) begin
        x = b_r; w_nxt.h_base = HUE_BASE_5; w_nxt.h_neg = 1'b0;
      end else begin
        x = g_r; w_nxt.h_base = HUE_BASE_1; w_nxt.h_neg = 1'b1;
      end
    end else if (val == g_r) begin
      if (white == b_r) begin
        x = r_r; w_nxt.h_base = HUE_BASE_1; w_nxt.h_neg = 1'b0;
      end else begin
        x = b_r; w_nxt.h_base = HUE_BASE_3; w_nxt.h_neg = 1'b1;
      end
    end else begin
      if (white == r_r) begin
        x = g_r; w_nxt.h_base = HUE_BASE_3; w_nxt.h_neg = 1'b0;
      end else begin
        x = r_r; w_nxt.h_base = HUE_BASE_5; w_nxt.h_neg = 1'b1;
      end
    end
    w_nxt.s_rem = {span, 8'd0} - {8'd0, span};
    w_nxt.s_den = val;
    w_nxt.h_rem = {(val - x), 8'd0} - {8'd0, (val - x)};
    w_nxt.h_den = span;
    w_nxt.val   = val;
  end

  assign out_valid = v2_r;
  assign out_word  = w_r;

endmodule

>>> rtl/core/rgbhsv_div_cell.sv
// One restoring-division cell: resolves one quotient bit of both quotients.
// Depends on rgbhsv_pkg.
`timescale 1ns / 1ps
module rgbhsv_div_cell import rgbhsv_pkg::*; #(
  parameter int unsigned BIT = 7
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic      in_valid,
  input  div_word_t in_word,
  output logic      out_valid,
  output div_word_t out_word
);

  logic      v_r;
  div_word_t w_r, w_nxt;
  logic [NUM_W:0] s_sub, h_sub;

  always_comb begin
    w_nxt = in_word;
    s_sub = {1'b0, in_word.s_rem} - ({9'd0, in_word.s_den} << BIT);
    h_sub = {1'b0, in_word.h_rem} - ({9'd0, in_word.h_den} << BIT);
    if (!s_sub[NUM_W]) begin
      w_nxt.s_rem      = s_sub[NUM_W-1:0];
      w_nxt.s_quo[BIT] = 1'b1;
    end
    if (!h_sub[NUM_W]) begin
      w_nxt.h_rem      = h_sub[NUM_W-1:0];
      w_nxt.h_quo[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w_r <= w_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_word  = w_r;

endmodule

>>> rtl/core/rgbhsv_post.sv
// Back stages: quotient rounding, hue sum and rounded divide by six.
// Depends on rgbhsv_pkg.
`timescale 1ns / 1ps
module rgbhsv_post import rgbhsv_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  div_word_t         in_word,
  output logic              out_valid,
  output logic [CHAN_W-1:0] hue,
  output logic [CHAN_W-1:0] sat,
  output logic [CHAN_W-1:0] val
);

  logic              v1_r, v2_r;
  logic [CHAN_W-1:0] sat1_r, sat1_nxt, val1_r;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CHAN_W-1:0] hue_r, hue_nxt, sat2_r, val2_r;
  logic [CHAN_W-1:0] c_fin;
  logic [SUM_W-1:0]  n6;
  logic [24:0]       p6;

  always_comb begin
    sat1_nxt = in_word.s_quo
             + 8'(({in_word.s_rem[7:0], 1'b0} >= {1'b0, in_word.s_den}) ? 1 : 0);
    if (in_word.val == '0) sat1_nxt = '0;
    c_fin    = in_word.h_quo
             + 8'(({in_word.h_rem[7:0], 1'b0} >= {1'b0, in_word.h_den}) ? 1 : 0);
    sum_nxt  = in_word.h_neg ? (in_word.h_base - {3'd0, c_fin})
                             : (in_word.h_base + {3'd0, c_fin});
  end

  always_comb begin
    n6      = sum_r + 11'd3;
    p6      = 25'(n6) * 25'(RECIP_6);
    hue_nxt = (sat1_r == '0) ? '0 : p6[23:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sat1_r <= sat1_nxt;
      val1_r <= in_word.val;
      sum_r  <= sum_nxt;
      hue_r  <= hue_nxt;
      sat2_r <= sat1_r;
      val2_r <= val1_r;
    end
  end

  assign out_valid = v2_r;
  assign hue       = hue_r;
  assign sat       = sat2_r;
  assign val       = val2_r;

endmodule

>>> rtl/core/rgb6_to_hsv8_convert_core.sv
// Top level of the 6-bit RGB to 8-bit HSV converter.
// Depends on rgbhsv_pkg, rgbhsv_prep, rgbhsv_div_cell and rgbhsv_post.
//
// Takes one colour word per cycle and returns one HSV word per colour, in
// order, through two front stages, a row of eight division cells that each
// resolve one quotient bit of saturation and hue, and two back stages. All
// stages advance together; a stalled result holds the whole row and stalls
// the input.
`timescale 1ns / 1ps
module rgb6_to_hsv8_convert_core import rgbhsv_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [GUN_W-1:0]  in_red_in,
  input  logic [GUN_W-1:0]  in_green_in,
  input  logic [GUN_W-1:0]  in_blue_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAN_W-1:0] out_hue,
  output logic [CHAN_W-1:0] out_saturation,
  output logic [CHAN_W-1:0] out_brightness
);

  logic      adv;
  logic      cv [DIV_STEPS+1];
  div_word_t cw [DIV_STEPS+1];

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  rgbhsv_prep u_prep (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(in_valid),
    .red(in_red_in), .green(in_green_in), .blue(in_blue_in),
    .out_valid(cv[0]), .out_word(cw[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
    rgbhsv_div_cell #(.BIT(DIV_STEPS - 1 - i)) u_cell (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .in_valid(cv[i]), .in_word(cw[i]),
      .out_valid(cv[i+1]), .out_word(cw[i+1])
    );
  end

  rgbhsv_post u_post (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_valid(cv[DIV_STEPS]), .in_word(cw[DIV_STEPS]),
    .out_valid(out_valid), .hue(out_hue), .sat(out_saturation), .val(out_brightness)
  );

endmodule
